### rtl/utg_pkg.sv
// utg_pkg: shared constants, types and font tables for the utf-8 glyph renderer
`timescale 1ns / 1ps

package utg_pkg;

  // display geometry
  localparam int unsigned DisplayWidth = 128;

  // cursor handling
  localparam int unsigned CursorW   = 8;
  localparam logic [CursorW-1:0] CursorMax = 8'd128;
  localparam logic [CursorW-1:0] Advance   = 8'd6;

  // byte codes
  localparam logic [7:0] LeadCode   = 8'hC3;
  localparam logic [7:0] LowerFirst = 8'h61;
  localparam logic [7:0] LowerLast  = 8'h7A;
  localparam logic [7:0] CaseOffset = 8'h20;
  localparam logic [7:0] FontFirst  = 8'h20;
  localparam logic [7:0] FontLast   = 8'h5A;
  localparam logic [7:0] AccentLo   = 8'h80;
  localparam logic [7:0] AccentHi   = 8'hBF;
  localparam logic [7:0] AccentFold = 8'hDF;
  localparam logic [7:0] NoLetter   = 8'h00;

  // umlaut follower codes
  localparam logic [7:0] UmlUpperA = 8'h84;
  localparam logic [7:0] UmlUpperO = 8'h96;
  localparam logic [7:0] UmlUpperU = 8'h9C;
  localparam logic [7:0] UmlLowerA = 8'hA4;
  localparam logic [7:0] UmlLowerO = 8'hB6;
  localparam logic [7:0] UmlLowerU = 8'hBC;

  localparam logic [2:0] UmlautNone = 3'd7;

  localparam int unsigned Cols = 5;

  // one glyph: element c is column c, bit r is row r
  typedef logic [Cols-1:0][6:0] glyph_t;

  function automatic glyph_t mk(input logic [6:0] c0, input logic [6:0] c1,
                                input logic [6:0] c2, input logic [6:0] c3,
                                input logic [6:0] c4);
    glyph_t g;
    g[0] = c0;
    g[1] = c1;
    g[2] = c2;
    g[3] = c3;
    g[4] = c4;
    return g;
  endfunction

  // saturating cursor step
  function automatic logic [CursorW-1:0] sat_advance(input logic [CursorW-1:0] cur);
    logic [CursorW:0] sum;
    sum = {1'b0, cur} + {1'b0, Advance};
    if (sum > {1'b0, CursorMax}) begin
      return CursorMax;
    end
    return sum[CursorW-1:0];
  endfunction

  function automatic logic [2:0] umlaut_index(input logic [7:0] b);
    case (b)
      UmlUpperA: return 3'd0;
      UmlUpperO: return 3'd1;
      UmlUpperU: return 3'd2;
      UmlLowerA: return 3'd3;
      UmlLowerO: return 3'd4;
      UmlLowerU: return 3'd5;
      default:   return UmlautNone;
    endcase
  endfunction

  // base letter of an accented follower, NoLetter if none
  function automatic logic [7:0] base_letter(input logic [7:0] b);
    logic [7:0] lo;
    lo = b & AccentFold;
    if (b < AccentLo || b > AccentHi) return NoLetter;
    if (lo <= 8'h85) return 8'h41;
    if (lo == 8'h87) return 8'h43;
    if (lo >= 8'h88 && lo <= 8'h8B) return 8'h45;
    if (lo >= 8'h8C && lo <= 8'h8F) return 8'h49;
    if (lo == 8'h91) return 8'h4E;
    if (lo >= 8'h92 && lo <= 8'h98) return 8'h4F;
    if (lo >= 8'h99 && lo <= 8'h9B) return 8'h55;
    if (lo == 8'h9D) return 8'h59;
    return NoLetter;
  endfunction

  function automatic glyph_t umlaut_glyph(input logic [2:0] idx);
    case (idx)
      3'd0:    return mk(7'h7D, 7'h12, 7'h11, 7'h12, 7'h7D);
      3'd1:    return mk(7'h3D, 7'h42, 7'h41, 7'h42, 7'h3D);
      3'd2:    return mk(7'h3E, 7'h41, 7'h40, 7'h41, 7'h3E);
      3'd3:    return mk(7'h22, 7'h54, 7'h54, 7'h54, 7'h78);
      3'd4:    return mk(7'h38, 7'h45, 7'h44, 7'h45, 7'h38);
      3'd5:    return mk(7'h3C, 7'h41, 7'h40, 7'h41, 7'h7C);
      default: return '0;
    endcase
  endfunction

  // 5x7 font, index is ascii code minus 32
  function automatic glyph_t font_glyph(input logic [5:0] idx);
    case (idx)
      6'd0:    return mk(7'h00, 7'h00, 7'h00, 7'h00, 7'h00);
      6'd1:    return mk(7'h00, 7'h00, 7'h5F, 7'h00, 7'h00);
      6'd2:    return mk(7'h00, 7'h07, 7'h00, 7'h07, 7'h00);
      6'd3:    return mk(7'h14, 7'h7F, 7'h14, 7'h7F, 7'h14);
      6'd4:    return mk(7'h24, 7'h2A, 7'h7F, 7'h2A, 7'h12);
      6'd5:    return mk(7'h23, 7'h13, 7'h08, 7'h64, 7'h62);
      6'd6:    return mk(7'h36, 7'h49, 7'h55, 7'h22, 7'h50);
      6'd7:    return mk(7'h00, 7'h05, 7'h03, 7'h00, 7'h00);
      6'd8:    return mk(7'h00, 7'h1C, 7'h22, 7'h41, 7'h00);
      6'd9:    return mk(7'h00, 7'h41, 7'h22, 7'h1C, 7'h00);
      6'd10:   return mk(7'h08, 7'h2A, 7'h1C, 7'h2A, 7'h08);
      6'd11:   return mk(7'h08, 7'h08, 7'h3E, 7'h08, 7'h08);
      6'd12:   return mk(7'h00, 7'h50, 7'h30, 7'h00, 7'h00);
      6'd13:   return mk(7'h08, 7'h08, 7'h08, 7'h08, 7'h08);
      6'd14:   return mk(7'h00, 7'h60, 7'h60, 7'h00, 7'h00);
      6'd15:   return mk(7'h20, 7'h10, 7'h08, 7'h04, 7'h02);
      6'd16:   return mk(7'h3E, 7'h51, 7'h49, 7'h45, 7'h3E);
      6'd17:   return mk(7'h00, 7'h42, 7'h7F, 7'h40, 7'h00);
      6'd18:   return mk(7'h42, 7'h61, 7'h51, 7'h49, 7'h46);
      6'd19:   return mk(7'h21, 7'h41, 7'h45, 7'h4B, 7'h31);
      6'd20:   return mk(7'h18, 7'h14, 7'h12, 7'h7F, 7'h10);
      6'd21:   return mk(7'h27, 7'h45, 7'h45, 7'h45, 7'h39);
      6'd22:   return mk(7'h3C, 7'h4A, 7'h49, 7'h49, 7'h30);
      6'd23:   return mk(7'h01, 7'h71, 7'h09, 7'h05, 7'h03);
      6'd24:   return mk(7'h36, 7'h49, 7'h49, 7'h49, 7'h36);
      6'd25:   return mk(7'h06, 7'h49, 7'h49, 7'h29, 7'h1E);
      6'd26:   return mk(7'h00, 7'h36, 7'h36, 7'h00, 7'h00);
      6'd27:   return mk(7'h00, 7'h56, 7'h36, 7'h00, 7'h00);
      6'd28:   return mk(7'h08, 7'h14, 7'h22, 7'h41, 7'h00);
      6'd29:   return mk(7'h14, 7'h14, 7'h14, 7'h14, 7'h14);
      6'd30:   return mk(7'h00, 7'h41, 7'h22, 7'h14, 7'h08);
      6'd31:   return mk(7'h02, 7'h01, 7'h51, 7'h09, 7'h06);
      6'd32:   return mk(7'h32, 7'h49, 7'h79, 7'h41, 7'h3E);
      6'd33:   return mk(7'h7E, 7'h11, 7'h11, 7'h11, 7'h7E);
      6'd34:   return mk(7'h7F, 7'h49, 7'h49, 7'h49, 7'h36);
      6'd35:   return mk(7'h3E, 7'h41, 7'h41, 7'h41, 7'h22);
      6'd36:   return mk(7'h7F, 7'h41, 7'h41, 7'h22, 7'h1C);
      6'd37:   return mk(7'h7F, 7'h49, 7'h49, 7'h49, 7'h41);
      6'd38:   return mk(7'h7F, 7'h09, 7'h09, 7'h09, 7'h01);
      6'd39:   return mk(7'h3E, 7'h41, 7'h49, 7'h49, 7'h7A);
      6'd40:   return mk(7'h7F, 7'h08, 7'h08, 7'h08, 7'h7F);
      6'd41:   return mk(7'h00, 7'h41, 7'h7F, 7'h41, 7'h00);
      6'd42:   return mk(7'h20, 7'h40, 7'h41, 7'h3F, 7'h01);
      6'd43:   return mk(7'h7F, 7'h08, 7'h14, 7'h22, 7'h41);
      6'd44:   return mk(7'h7F, 7'h40, 7'h40, 7'h40, 7'h40);
      6'd45:   return mk(7'h7F, 7'h02, 7'h0C, 7'h02, 7'h7F);
      6'd46:   return mk(7'h7F, 7'h04, 7'h08, 7'h10, 7'h7F);
      6'd47:   return mk(7'h3E, 7'h41, 7'h41, 7'h41, 7'h3E);
      6'd48:   return mk(7'h7F, 7'h09, 7'h09, 7'h09, 7'h06);
      6'd49:   return mk(7'h3E, 7'h41, 7'h51, 7'h21, 7'h5E);
      6'd50:   return mk(7'h7F, 7'h09, 7'h19, 7'h29, 7'h46);
      6'd51:   return mk(7'h46, 7'h49, 7'h49, 7'h49, 7'h31);
      6'd52:   return mk(7'h01, 7'h01, 7'h7F, 7'h01, 7'h01);
      6'd53:   return mk(7'h3F, 7'h40, 7'h40, 7'h40, 7'h3F);
      6'd54:   return mk(7'h1F, 7'h20, 7'h40, 7'h20, 7'h1F);
      6'd55:   return mk(7'h3F, 7'h40, 7'h38, 7'h40, 7'h3F);
      6'd56:   return mk(7'h63, 7'h14, 7'h08, 7'h14, 7'h63);
      6'd57:   return mk(7'h07, 7'h08, 7'h70, 7'h08, 7'h07);
      6'd58:   return mk(7'h61, 7'h51, 7'h49, 7'h45, 7'h43);
      default: return '0;
    endcase
  endfunction

endpackage

### rtl/utg_in_if.sv
// utg_in_if: text byte channel with valid/ready handshake
`timescale 1ns / 1ps

interface utg_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       first_byte;
  logic       last_byte;
  logic [6:0] start_column;
  logic [5:0] start_row;

  modport source (
    output valid, text_byte, first_byte, last_byte, start_column, start_row,
    input  ready
  );

  modport sink (
    input  valid, text_byte, first_byte, last_byte, start_column, start_row,
    output ready
  );
endinterface

### rtl/utg_out_if.sv
// utg_out_if: glyph result channel with valid/ready handshake
`timescale 1ns / 1ps

interface utg_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] glyph_column;
  logic [5:0] glyph_row;
  logic [4:0] column_mask;
  logic [6:0] pattern_0;
  logic [6:0] pattern_1;
  logic [6:0] pattern_2;
  logic [6:0] pattern_3;
  logic [6:0] pattern_4;

  modport source (
    output valid, glyph_column, glyph_row, column_mask,
           pattern_0, pattern_1, pattern_2, pattern_3, pattern_4,
    input  ready
  );

  modport sink (
    input  valid, glyph_column, glyph_row, column_mask,
           pattern_0, pattern_1, pattern_2, pattern_3, pattern_4,
    output ready
  );
endinterface

### rtl/utf8_text_glyph_renderer_unit.sv
// utf8_text_glyph_renderer_unit: utf-8 text to 5x7 glyph column patterns
`timescale 1ns / 1ps

// Takes a text string one byte per transaction and turns each drawable
// character into one glyph transaction: its pixel column and row, a mask of
// the five columns that lie on the display, and five 7-bit column patterns.
// Lower-case ascii is drawn as upper case, 0xC3 umlaut pairs get their own
// glyphs and other latin-1 accented pairs draw their base letter. Every
// character moves the cursor by 6 pixels; the cursor stops at 128 and glyphs
// starting there are dropped. A byte with first_byte set loads the cursor and
// row from its start fields. Throughput is one byte per clock unless the
// output stalls: decoding, font lookup and the cursor update sit between the
// input handshake and a single result register, and the input stalls only
// while a finished result waits on a stalled output.

module utf8_text_glyph_renderer_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  utg_in_if.sink        in_i,
  utg_out_if.source     out_o
);
  import utg_pkg::*;

  typedef struct packed {
    logic [6:0] glyph_column;
    logic [5:0] glyph_row;
    logic [4:0] column_mask;
    glyph_t     pattern;
  } result_t;

  // text state
  logic [CursorW-1:0] cursor_q, cursor_d;
  logic [5:0]         line_row_q, line_row_d;
  logic               lead_pending_q, lead_pending_d;

  // result register
  logic    out_valid_q;
  result_t result_q, result_d;

  logic in_accept;
  logic emit;

  // decode scratch
  logic [CursorW-1:0] cur_base, cur_mid;
  logic               pend;
  logic               fresh;
  logic               have_glyph;
  logic               set_lead;
  logic [2:0]         uml_idx;
  logic [7:0]         base_chr;
  logic [7:0]         folded;
  logic [7:0]         font_code;
  glyph_t             glyph;
  logic [CursorW:0]   dwidth;
  logic [CursorW:0]   col_pos;

  // the input only waits while a held result is not taken
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_accept  = in_i.valid && in_i.ready;

  always_comb begin
    // first byte of a string restarts cursor, row and lead tracking
    cur_base   = in_i.first_byte ? {1'b0, in_i.start_column} : cursor_q;
    line_row_d = in_i.first_byte ? in_i.start_row : line_row_q;
    pend       = in_i.first_byte ? 1'b0 : lead_pending_q;

    uml_idx    = umlaut_index(in_i.text_byte);
    base_chr   = base_letter(in_i.text_byte);
    cur_mid    = cur_base;
    fresh      = 1'b1;
    have_glyph = 1'b0;
    set_lead   = 1'b0;
    glyph      = '0;
    folded     = in_i.text_byte;
    font_code  = base_chr - FontFirst;

    // follower of a pending lead byte
    if (pend) begin
      if (uml_idx != UmlautNone) begin
        glyph      = umlaut_glyph(uml_idx);
        have_glyph = 1'b1;
        fresh      = 1'b0;
      end else if (base_chr != NoLetter) begin
        glyph      = font_glyph(font_code[5:0]);
        have_glyph = 1'b1;
        fresh      = 1'b0;
      end else begin
        // unmatched lead takes its own cell, follower handled as fresh
        cur_mid = sat_advance(cur_base);
      end
    end

    if (fresh) begin
      if (in_i.text_byte == LeadCode && !in_i.last_byte) begin
        set_lead = 1'b1;
      end else begin
        if (in_i.text_byte >= LowerFirst && in_i.text_byte <= LowerLast) begin
          folded = in_i.text_byte - CaseOffset;
        end
        font_code = folded - FontFirst;
        if (folded >= FontFirst && folded <= FontLast) begin
          glyph      = font_glyph(font_code[5:0]);
          have_glyph = 1'b1;
        end
      end
    end

    emit           = have_glyph && (cur_mid < CursorMax);
    lead_pending_d = set_lead;
    // a new lead byte holds the cursor, everything else takes one cell
    cursor_d       = set_lead ? cur_mid : sat_advance(cur_mid);

    // clip columns that fall off the right edge
    dwidth  = (CursorW + 1)'(DisplayWidth);
    col_pos = '0;
    result_d.column_mask = '0;
    for (int c = 0; c < Cols; c++) begin
      col_pos = {1'b0, cur_mid} + (CursorW + 1)'(c);
      result_d.column_mask[c] = (col_pos < dwidth);
    end
    result_d.glyph_column = cur_mid[6:0];
    result_d.glyph_row    = line_row_d;
    result_d.pattern      = glyph;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_q       <= '0;
      line_row_q     <= '0;
      lead_pending_q <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      if (in_accept) begin
        cursor_q       <= cursor_d;
        line_row_q     <= line_row_d;
        lead_pending_q <= lead_pending_d;
        out_valid_q    <= emit;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload only moves when a new glyph is loaded
  always_ff @(posedge clk_i) begin
    if (in_accept && emit) begin
      result_q <= result_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.glyph_column = result_q.glyph_column;
  assign out_o.glyph_row    = result_q.glyph_row;
  assign out_o.column_mask  = result_q.column_mask;
  assign out_o.pattern_0    = result_q.pattern[0];
  assign out_o.pattern_1    = result_q.pattern[1];
  assign out_o.pattern_2    = result_q.pattern[2];
  assign out_o.pattern_3    = result_q.pattern[3];
  assign out_o.pattern_4    = result_q.pattern[4];

`ifndef SYNTHESIS
  // cursor never runs past its saturation point
  a_cursor_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cursor_q <= CursorMax)
    else $error("cursor beyond saturation");

  // a stalled input always means a result is held
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> out_valid_q)
    else $error("input stalled without held result");

  // a drawn glyph shows up in the next cycle
  a_emit_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && emit |=> out_valid_q)
    else $error("emitted glyph missing");

  // a pending lead byte produces no transaction
  a_lead_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && lead_pending_d |=> !out_valid_q)
    else $error("lead byte produced a result");

  // a drawn glyph leaves no lead pending and moves the cursor off zero
  a_column_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && emit |=> !lead_pending_q && (cursor_q != '0))
    else $error("cursor did not advance after glyph");
`endif

endmodule

### tb/tb_utf8_text_glyph_renderer_unit.sv
// tb_utf8_text_glyph_renderer_unit: self-checking bench for the utf-8 5x7 glyph renderer
`timescale 1ns / 1ps

module tb_utf8_text_glyph_renderer_unit;

  // quiet cycles with no transaction on either side before the run is called hung
  localparam int unsigned HangLimit = 400;
  // random byte budget once the directed table is done
  localparam int unsigned RandomBytes = 1250;

  // one glyph transaction as it leaves the block
  typedef struct packed {
    logic [6:0]       column;
    logic [5:0]       row;
    logic [4:0]       mask;
    logic [0:4][6:0]  pattern;
  } glyph_res_t;

  // one text byte transaction, plus an optional hand-written expectation
  typedef struct packed {
    logic [7:0] text_byte;
    logic       first;
    logic       last;
    logic [6:0] start_column;
    logic [5:0] start_row;
    logic       typed;
    logic       drawn;
    glyph_res_t res;
  } text_item_t;

  // 5x7 font for ascii 32..90, column 0 first, bit r is pixel row r
  localparam logic [0:58][0:4][6:0] FONT_ROM = {
    7'h00, 7'h00, 7'h00, 7'h00, 7'h00,  7'h00, 7'h00, 7'h5F, 7'h00, 7'h00,
    7'h00, 7'h07, 7'h00, 7'h07, 7'h00,  7'h14, 7'h7F, 7'h14, 7'h7F, 7'h14,
    7'h24, 7'h2A, 7'h7F, 7'h2A, 7'h12,  7'h23, 7'h13, 7'h08, 7'h64, 7'h62,
    7'h36, 7'h49, 7'h55, 7'h22, 7'h50,  7'h00, 7'h05, 7'h03, 7'h00, 7'h00,
    7'h00, 7'h1C, 7'h22, 7'h41, 7'h00,  7'h00, 7'h41, 7'h22, 7'h1C, 7'h00,
    7'h08, 7'h2A, 7'h1C, 7'h2A, 7'h08,  7'h08, 7'h08, 7'h3E, 7'h08, 7'h08,
    7'h00, 7'h50, 7'h30, 7'h00, 7'h00,  7'h08, 7'h08, 7'h08, 7'h08, 7'h08,
    7'h00, 7'h60, 7'h60, 7'h00, 7'h00,  7'h20, 7'h10, 7'h08, 7'h04, 7'h02,
    7'h3E, 7'h51, 7'h49, 7'h45, 7'h3E,  7'h00, 7'h42, 7'h7F, 7'h40, 7'h00,
    7'h42, 7'h61, 7'h51, 7'h49, 7'h46,  7'h21, 7'h41, 7'h45, 7'h4B, 7'h31,
    7'h18, 7'h14, 7'h12, 7'h7F, 7'h10,  7'h27, 7'h45, 7'h45, 7'h45, 7'h39,
    7'h3C, 7'h4A, 7'h49, 7'h49, 7'h30,  7'h01, 7'h71, 7'h09, 7'h05, 7'h03,
    7'h36, 7'h49, 7'h49, 7'h49, 7'h36,  7'h06, 7'h49, 7'h49, 7'h29, 7'h1E,
    7'h00, 7'h36, 7'h36, 7'h00, 7'h00,  7'h00, 7'h56, 7'h36, 7'h00, 7'h00,
    7'h08, 7'h14, 7'h22, 7'h41, 7'h00,  7'h14, 7'h14, 7'h14, 7'h14, 7'h14,
    7'h00, 7'h41, 7'h22, 7'h14, 7'h08,  7'h02, 7'h01, 7'h51, 7'h09, 7'h06,
    7'h32, 7'h49, 7'h79, 7'h41, 7'h3E,  7'h7E, 7'h11, 7'h11, 7'h11, 7'h7E,
    7'h7F, 7'h49, 7'h49, 7'h49, 7'h36,  7'h3E, 7'h41, 7'h41, 7'h41, 7'h22,
    7'h7F, 7'h41, 7'h41, 7'h22, 7'h1C,  7'h7F, 7'h49, 7'h49, 7'h49, 7'h41,
    7'h7F, 7'h09, 7'h09, 7'h09, 7'h01,  7'h3E, 7'h41, 7'h49, 7'h49, 7'h7A,
    7'h7F, 7'h08, 7'h08, 7'h08, 7'h7F,  7'h00, 7'h41, 7'h7F, 7'h41, 7'h00,
    7'h20, 7'h40, 7'h41, 7'h3F, 7'h01,  7'h7F, 7'h08, 7'h14, 7'h22, 7'h41,
    7'h7F, 7'h40, 7'h40, 7'h40, 7'h40,  7'h7F, 7'h02, 7'h0C, 7'h02, 7'h7F,
    7'h7F, 7'h04, 7'h08, 7'h10, 7'h7F,  7'h3E, 7'h41, 7'h41, 7'h41, 7'h3E,
    7'h7F, 7'h09, 7'h09, 7'h09, 7'h06,  7'h3E, 7'h41, 7'h51, 7'h21, 7'h5E,
    7'h7F, 7'h09, 7'h19, 7'h29, 7'h46,  7'h46, 7'h49, 7'h49, 7'h49, 7'h31,
    7'h01, 7'h01, 7'h7F, 7'h01, 7'h01,  7'h3F, 7'h40, 7'h40, 7'h40, 7'h3F,
    7'h1F, 7'h20, 7'h40, 7'h20, 7'h1F,  7'h3F, 7'h40, 7'h38, 7'h40, 7'h3F,
    7'h63, 7'h14, 7'h08, 7'h14, 7'h63,  7'h07, 7'h08, 7'h70, 7'h08, 7'h07,
    7'h61, 7'h51, 7'h49, 7'h45, 7'h43
  };

  // umlaut followers after the lead byte and their glyphs, same order
  localparam logic [0:5][7:0] UML_CODES = {
    utg_pkg::UmlUpperA, utg_pkg::UmlUpperO, utg_pkg::UmlUpperU,
    utg_pkg::UmlLowerA, utg_pkg::UmlLowerO, utg_pkg::UmlLowerU
  };
  localparam logic [0:5][0:4][6:0] UML_ROM = {
    7'h7D, 7'h12, 7'h11, 7'h12, 7'h7D,  7'h3D, 7'h42, 7'h41, 7'h42, 7'h3D,
    7'h3E, 7'h41, 7'h40, 7'h41, 7'h3E,  7'h22, 7'h54, 7'h54, 7'h54, 7'h78,
    7'h38, 7'h45, 7'h44, 7'h45, 7'h38,  7'h3C, 7'h41, 7'h40, 7'h41, 7'h7C
  };

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  utg_in_if  in_if ();
  utg_out_if out_if ();

  utf8_text_glyph_renderer_unit u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // predictor copy of the block state
  logic [7:0] pen_column;
  logic [5:0] pen_row;
  logic       lead_held;

  glyph_res_t expected_glyphs[$];
  int unsigned err_cnt = 0;
  int unsigned idle_cycles = 0;
  bit src_quiet = 1'b0;
  bit sink_quiet = 1'b0;

  // move the pen one character cell, stopping at the right edge
  task automatic step_pen();
    pen_column = (pen_column + utg_pkg::Advance > utg_pkg::CursorMax) ?
                 utg_pkg::CursorMax : pen_column + utg_pkg::Advance;
  endtask

  // decode one text byte against the predictor state and say what it draws
  task automatic render_byte(input text_item_t it, output bit drawn, output glyph_res_t res);
    logic [7:0]      b;
    logic [7:0]      base;
    logic [4:0]      lo;
    logic [0:4][6:0] cols;
    bit              fresh;
    bit              have;
    int              slot;
    drawn = 1'b0;
    res   = '0;
    b     = it.text_byte;
    fresh = 1'b1;
    have  = 1'b0;
    cols  = '0;
    if (it.first) begin
      pen_column = {1'b0, it.start_column};
      pen_row    = it.start_row;
      lead_held  = 1'b0;
    end
    if (lead_held) begin
      lead_held = 1'b0;
      slot = -1;
      for (int k = 0; k < 6; k++) begin
        if (UML_CODES[k] == b) slot = k;
      end
      // accented followers 0x80..0xBF: the 0xA0 half mirrors the 0x80 half
      base = 8'h00;
      lo   = b[4:0];
      if (b[7:6] == 2'b10) begin
        if (lo <= 5'h05)                    base = "A";
        else if (lo == 5'h07)               base = "C";
        else if (lo >= 5'h08 && lo <= 5'h0B) base = "E";
        else if (lo >= 5'h0C && lo <= 5'h0F) base = "I";
        else if (lo == 5'h11)               base = "N";
        else if (lo >= 5'h12 && lo <= 5'h18) base = "O";
        else if (lo >= 5'h19 && lo <= 5'h1B) base = "U";
        else if (lo == 5'h1D)               base = "Y";
      end
      if (slot >= 0) begin
        cols  = UML_ROM[slot];
        have  = 1'b1;
        fresh = 1'b0;
      end else if (base != 8'h00) begin
        cols  = FONT_ROM[base - utg_pkg::FontFirst];
        have  = 1'b1;
        fresh = 1'b0;
      end else begin
        // unmatched lead takes its own cell, follower handled as a new byte
        step_pen();
      end
    end
    if (fresh) begin
      if (b == utg_pkg::LeadCode && !it.last) begin
        lead_held = 1'b1;
        return;
      end
      if (b >= utg_pkg::LowerFirst && b <= utg_pkg::LowerLast) b = b - utg_pkg::CaseOffset;
      if (b >= utg_pkg::FontFirst && b <= utg_pkg::FontLast) begin
        cols = FONT_ROM[b - utg_pkg::FontFirst];
        have = 1'b1;
      end
    end
    if (have && pen_column < utg_pkg::CursorMax) begin
      drawn      = 1'b1;
      res.column = pen_column[6:0];
      res.row    = pen_row;
      res.pattern = cols;
      for (int c = 0; c < 5; c++) begin
        res.mask[c] = (pen_column + c) < utg_pkg::DisplayWidth;
      end
    end
    step_pen();
  endtask

  // offer one byte, wait for its transaction, then record what it should draw
  task automatic send_byte(input text_item_t it);
    bit         drawn;
    glyph_res_t res;
    int         gap;
    in_if.valid        <= 1'b1;
    in_if.text_byte    <= it.text_byte;
    in_if.first_byte   <= it.first;
    in_if.last_byte    <= it.last;
    in_if.start_column <= it.start_column;
    in_if.start_row    <= it.start_row;
    do @(posedge clk_i); while (!in_if.ready);
    render_byte(it, drawn, res);
    // hand-written rows override the predictor, which still tracks the state
    if (it.typed) begin
      drawn = it.drawn;
      res   = it.res;
    end
    if (drawn) expected_glyphs.push_back(res);
    gap = src_quiet ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // hold the input off until every glyph in flight has come out
  task automatic drain_glyphs();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (expected_glyphs.size() != 0) @(posedge clk_i);
  endtask

  function automatic text_item_t row(input logic [7:0] b, input logic f, input logic l,
                                     input logic [6:0] sc, input logic [5:0] sr);
    text_item_t it;
    it = '0;
    it.text_byte    = b;
    it.first        = f;
    it.last         = l;
    it.start_column = sc;
    it.start_row    = sr;
    return it;
  endfunction

  function automatic text_item_t row_none(input logic [7:0] b, input logic f, input logic l,
                                          input logic [6:0] sc, input logic [5:0] sr);
    text_item_t it;
    it       = row(b, f, l, sc, sr);
    it.typed = 1'b1;
    return it;
  endfunction

  function automatic text_item_t row_glyph(input logic [7:0] b, input logic f,
                                           input logic [6:0] sc, input logic [5:0] sr,
                                           input logic [6:0] col, input logic [5:0] gr,
                                           input logic [4:0] m, input logic [0:4][6:0] p);
    text_item_t it;
    it             = row(b, f, 1'b0, sc, sr);
    it.typed       = 1'b1;
    it.drawn       = 1'b1;
    it.res.column  = col;
    it.res.row     = gr;
    it.res.mask    = m;
    it.res.pattern = p;
    return it;
  endfunction

  task automatic flag_mismatch(input string what, input logic [7:0] exp_v,
                               input logic [7:0] act_v);
    $display("%0t ns: %s mismatch, expected %0h, actual %0h", $realtime, what, exp_v, act_v);
    err_cnt++;
  endtask

  // every glyph transaction is matched against the oldest expectation
  always @(posedge clk_i) begin
    glyph_res_t exp_g;
    if (out_if.valid && out_if.ready) begin
      if (expected_glyphs.size() == 0) begin
        $display("%0t ns: glyph at column %0h row %0h with nothing expected", $realtime,
                 out_if.glyph_column, out_if.glyph_row);
        err_cnt++;
      end else begin
        exp_g = expected_glyphs.pop_front();
        if (out_if.glyph_column !== exp_g.column)
          flag_mismatch("glyph_column", 8'(exp_g.column), 8'(out_if.glyph_column));
        if (out_if.glyph_row !== exp_g.row)
          flag_mismatch("glyph_row", 8'(exp_g.row), 8'(out_if.glyph_row));
        if (out_if.column_mask !== exp_g.mask)
          flag_mismatch("column_mask", 8'(exp_g.mask), 8'(out_if.column_mask));
        if (out_if.pattern_0 !== exp_g.pattern[0])
          flag_mismatch("pattern_0", 8'(exp_g.pattern[0]), 8'(out_if.pattern_0));
        if (out_if.pattern_1 !== exp_g.pattern[1])
          flag_mismatch("pattern_1", 8'(exp_g.pattern[1]), 8'(out_if.pattern_1));
        if (out_if.pattern_2 !== exp_g.pattern[2])
          flag_mismatch("pattern_2", 8'(exp_g.pattern[2]), 8'(out_if.pattern_2));
        if (out_if.pattern_3 !== exp_g.pattern[3])
          flag_mismatch("pattern_3", 8'(exp_g.pattern[3]), 8'(out_if.pattern_3));
        if (out_if.pattern_4 !== exp_g.pattern[4])
          flag_mismatch("pattern_4", 8'(exp_g.pattern[4]), 8'(out_if.pattern_4));
      end
    end
  end

  // hang detector: count cycles with no transaction on either channel
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= HangLimit) begin
        $display("tb_utf8_text_glyph_renderer_unit: errors");
        $finish;
      end
    end
  end

  // glyph receiver: random back-pressure, ready stays up through quiet stretches
  initial begin : glyph_sink
    int stall;
    out_if.ready = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      stall = sink_quiet ? 0 : $urandom_range(0, 11);
      if (stall != 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
    end
  end

  initial begin : text_source
    text_item_t dir_rows[$];
    logic [7:0] str[$];
    logic [6:0] scol;
    logic [5:0] srow;
    int         sent;
    int         strings;
    int         len;
    int         pick;
    in_if.valid        = 1'b0;
    in_if.text_byte    = '0;
    in_if.first_byte   = 1'b0;
    in_if.last_byte    = 1'b0;
    in_if.start_column = '0;
    in_if.start_row    = '0;
    pen_column = '0;
    pen_row    = '0;
    lead_held  = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table: font edges, folding, umlauts, lead byte corner cases, clipping
    dir_rows.push_back(row_glyph(8'h41, 1'b1, 7'd0, 6'd0, 7'd0, 6'd0, 5'h1F,
                                 {7'h7E, 7'h11, 7'h11, 7'h11, 7'h7E}));
    dir_rows.push_back(row_glyph(8'h20, 1'b0, 7'd0, 6'd0, 7'd6, 6'd0, 5'h1F,
                                 {7'h00, 7'h00, 7'h00, 7'h00, 7'h00}));
    dir_rows.push_back(row_glyph(8'h5A, 1'b0, 7'd0, 6'd0, 7'd12, 6'd0, 5'h1F,
                                 {7'h61, 7'h51, 7'h49, 7'h45, 7'h43}));
    dir_rows.push_back(row_none(8'h00, 1'b0, 1'b0, 7'd0, 6'd0));
    dir_rows.push_back(row_none(utg_pkg::LeadCode, 1'b0, 1'b0, 7'd0, 6'd0));
    dir_rows.push_back(row_glyph(utg_pkg::UmlUpperA, 1'b0, 7'd0, 6'd0, 7'd24, 6'd0, 5'h1F,
                                 {7'h7D, 7'h12, 7'h11, 7'h12, 7'h7D}));
    dir_rows.push_back(row_none(utg_pkg::LeadCode, 1'b0, 1'b0, 7'd0, 6'd0));
    dir_rows.push_back(row_glyph(utg_pkg::UmlLowerU, 1'b0, 7'd0, 6'd0, 7'd30, 6'd0, 5'h1F,
                                 {7'h3C, 7'h41, 7'h40, 7'h41, 7'h7C}));
    // accent folds to its base letter, including the odd 0x97 case
    dir_rows.push_back(row(utg_pkg::LeadCode, 1'b0, 1'b0, 7'd0, 6'd0));
    dir_rows.push_back(row(8'hA9, 1'b0, 1'b0, 7'd0, 6'd0));
    dir_rows.push_back(row(utg_pkg::LeadCode, 1'b0, 1'b0, 7'd0, 6'd0));
    dir_rows.push_back(row(8'h97, 1'b0, 1'b0, 7'd0, 6'd0));
    // unmatched lead, then a lead that follows a lead
    dir_rows.push_back(row(utg_pkg::LeadCode, 1'b0, 1'b0, 7'd0, 6'd0));
    dir_rows.push_back(row(8'h41, 1'b0, 1'b0, 7'd0, 6'd0));
    dir_rows.push_back(row(utg_pkg::LeadCode, 1'b0, 1'b0, 7'd0, 6'd0));
    dir_rows.push_back(row(utg_pkg::LeadCode, 1'b0, 1'b0, 7'd0, 6'd0));
    dir_rows.push_back(row(utg_pkg::UmlUpperO, 1'b0, 1'b0, 7'd0, 6'd0));
    // lead byte marked last only moves the pen
    dir_rows.push_back(row_none(utg_pkg::LeadCode, 1'b0, 1'b1, 7'd0, 6'd0));
    // far right edge and bottom row: one visible column, then saturated pen
    dir_rows.push_back(row_glyph(8'h57, 1'b1, 7'd127, 6'd57, 7'd127, 6'd57, 5'h01,
                                 {7'h3F, 7'h40, 7'h38, 7'h40, 7'h3F}));
    dir_rows.push_back(row_none(8'h42, 1'b0, 1'b0, 7'd0, 6'd0));
    dir_rows.push_back(row(utg_pkg::LeadCode, 1'b0, 1'b0, 7'd0, 6'd0));
    dir_rows.push_back(row(utg_pkg::UmlLowerO, 1'b0, 1'b1, 7'd0, 6'd0));
    dir_rows.push_back(row_glyph(8'h4D, 1'b1, 7'd124, 6'd0, 7'd124, 6'd0, 5'h0F,
                                 {7'h7F, 7'h02, 7'h0C, 7'h02, 7'h7F}));
    // a new string drops a held lead, so its follower is a lone byte
    dir_rows.push_back(row(utg_pkg::LeadCode, 1'b0, 1'b0, 7'd0, 6'd0));
    dir_rows.push_back(row_none(utg_pkg::UmlUpperA, 1'b1, 1'b0, 7'd0, 6'd10));
    dir_rows.push_back(row_glyph(8'h7A, 1'b0, 7'd0, 6'd0, 7'd6, 6'd10, 5'h1F,
                                 {7'h61, 7'h51, 7'h49, 7'h45, 7'h43}));
    foreach (dir_rows[i]) send_byte(dir_rows[i]);
    drain_glyphs();

    // random strings: mostly well-formed text, some noise with stray flags
    sent    = 0;
    strings = 0;
    while (sent < RandomBytes) begin
      src_quiet  = ($urandom_range(0, 4) == 0);
      sink_quiet = ($urandom_range(0, 4) == 0);
      str.delete();
      if ($urandom_range(0, 9) == 0) begin
        len = $urandom_range(1, 16);
        repeat (len) begin
          scol = 7'($urandom_range(0, 127));
          srow = 6'($urandom_range(0, 57));
          send_byte(row(8'($urandom_range(0, 255)), ($urandom_range(0, 3) == 0),
                        ($urandom_range(0, 3) == 0), scol, srow));
        end
        sent += len;
      end else begin
        len = $urandom_range(1, 24);
        while (str.size() < len) begin
          pick = $urandom_range(0, 99);
          if (pick < 30) begin
            str.push_back(8'($urandom_range(32, 90)));
          end else if (pick < 50) begin
            str.push_back(8'($urandom_range(97, 122)));
          end else if (pick < 62) begin
            str.push_back(utg_pkg::LeadCode);
            str.push_back(UML_CODES[$urandom_range(0, 5)]);
          end else if (pick < 74) begin
            str.push_back(utg_pkg::LeadCode);
            str.push_back(8'($urandom_range(128, 191)));
          end else if (pick < 82) begin
            str.push_back(utg_pkg::LeadCode);
            str.push_back(8'($urandom_range(0, 255)));
          end else begin
            str.push_back(8'($urandom_range(0, 255)));
          end
        end
        // now and then the string ends on a dangling lead
        if ($urandom_range(0, 19) == 0) str.push_back(utg_pkg::LeadCode);
        scol = ($urandom_range(0, 2) != 0) ? 7'($urandom_range(0, 40)) :
                                             7'($urandom_range(0, 127));
        srow = 6'($urandom_range(0, 57));
        foreach (str[k]) begin
          send_byte(row(str[k], (k == 0), (k == str.size() - 1), scol, srow));
        end
        sent += str.size();
      end
      strings++;
      if (strings % 15 == 0) drain_glyphs();
    end

    src_quiet  = 1'b0;
    sink_quiet = 1'b0;
    drain_glyphs();
    repeat (4) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("tb_utf8_text_glyph_renderer_unit: clean");
    end else begin
      $display("tb_utf8_text_glyph_renderer_unit: errors");
    end
    $finish;
  end

endmodule
